// ===== rtl/core/kct_pkg.sv =====
// Shared constants and types for the k-means codebook trainer.
package kct_pkg;

   // Fixed field widths.
   localparam int VAL_W    = 16;
   localparam int ERR_W    = 46;
   localparam int PASS_W   = 8;
   localparam int VCFG_W   = 11;
   localparam int CAP_W    = 8;
   localparam int SQ_W     = 32;
   localparam int CSR_IX_W = 1;

   // Request modes.
   localparam logic [1:0] MODE_LOAD_SAMPLE   = 2'd0;
   localparam logic [1:0] MODE_LOAD_CENTROID = 2'd1;
   localparam logic [1:0] MODE_START         = 2'd2;
   localparam logic [1:0] MODE_READ          = 2'd3;

   // Response status codes.
   localparam logic [1:0] STATUS_READBACK  = 2'd0;
   localparam logic [1:0] STATUS_CONVERGED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_CAP       = 2'd3;

   // Register indexes.
   localparam logic [CSR_IX_W-1:0] CSR_VECTOR_COUNT  = 1'd0;
   localparam logic [CSR_IX_W-1:0] CSR_ITERATION_CAP = 1'd1;

   // Register reset values.
   localparam logic [VCFG_W-1:0] VCOUNT_RESET = 11'd1024;
   localparam logic [CAP_W-1:0]  ICAP_RESET   = 8'd64;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } kct_div_stat_type;

endpackage

// ===== rtl/core/kct_divider.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module kct_divider #(
   parameter int SUM_W = 26,
   parameter int CNT_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_W-1:0]       dividend,
   input  logic        [CNT_W-1:0]       divisor,
   output logic        [kct_pkg::VAL_W-1:0] quotient,
   output kct_pkg::kct_div_stat_type     stat
);
   import kct_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  mag_ff, mag_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [CNT_W:0]    rem_sh;
   logic              ge;
   logic [SUM_W-1:0]  signed_q;

   // One restoring step: shift in the next dividend bit, subtract when it fits.
   always_comb begin
      rem_sh  = {rem_ff, mag_ff[SUM_W-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? CNT_W'(rem_sh - {1'b0, den_ff}) : rem_sh[CNT_W-1:0];
         mag_in  = {mag_ff[SUM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   // Apply the sign and keep the low word.
   assign signed_q  = neg_ff ? (~mag_ff + 1'b1) : mag_ff;
   assign quotient  = signed_q[VAL_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/kmeans_codebook_trainer.sv =====
// Lloyd k-means codebook trainer: sample, centroid and sum memories with a pass sequencer.
// Loads write the memory when the request is taken; a readback reads the centroid memory and then
// registers its word, and no request is taken until that word is out. A run does assignment and
// accumulation each pass, paced by the single read port of the sample memory, then centroid division
// in the one shared divider; its response word comes when the run stops.
// Synchronous reset clears control state, sets register defaults; memories are undefined until written.
module kmeans_codebook_trainer #(
   parameter int NUM_CLUSTERS = 5,
   parameter int DIMENSIONS   = 13,
   parameter int MAX_VECTORS  = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic [9:0]                         req_vector_index,
   input  logic [3:0]                         req_component,
   input  logic signed [kct_pkg::VAL_W-1:0]   req_sample_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [kct_pkg::VAL_W-1:0]   rsp_centroid_value,
   output logic [kct_pkg::ERR_W-1:0]          rsp_total_error,
   output logic [1:0]                         rsp_status,
   output logic [kct_pkg::PASS_W-1:0]         rsp_passes_done,
   input  logic                               csr_we,
   input  logic [kct_pkg::CSR_IX_W-1:0]       csr_index,
   input  logic [kct_pkg::VCFG_W-1:0]         csr_wdata
);
   import kct_pkg::*;

   localparam int VIDX_W = $clog2(MAX_VECTORS);
   localparam int VCNT_W = $clog2(MAX_VECTORS + 1);
   localparam int SA_W   = $clog2(MAX_VECTORS * DIMENSIONS);
   localparam int CA_W   = $clog2(NUM_CLUSTERS * DIMENSIONS);
   localparam int CL_W   = $clog2(NUM_CLUSTERS);
   localparam int DIM_W  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
   localparam int SUM_W  = VAL_W + VIDX_W;
   localparam int CNT_W  = VCNT_W;
   localparam int DIST_W = SQ_W + $clog2(DIMENSIONS);
   localparam int CMP_W  = (VCNT_W > VCFG_W) ? VCNT_W : VCFG_W;
   localparam int SDEPTH = MAX_VECTORS * DIMENSIONS;
   localparam int CDEPTH = NUM_CLUSTERS * DIMENSIONS;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PASS   = 4'd1;
   localparam logic [3:0] S_DIST   = 4'd2;
   localparam logic [3:0] S_DDRAIN = 4'd3;
   localparam logic [3:0] S_ACC    = 4'd4;
   localparam logic [3:0] S_CHECK  = 4'd5;
   localparam logic [3:0] S_DRD    = 4'd6;
   localparam logic [3:0] S_DSTART = 4'd7;
   localparam logic [3:0] S_DWT    = 4'd8;
   localparam logic [3:0] S_END    = 4'd9;

   // Memories.
   logic [VAL_W-1:0]        smem [SDEPTH];
   logic [VAL_W-1:0]        cmem [CDEPTH];
   logic signed [SUM_W-1:0] umem [CDEPTH];

   logic [VAL_W-1:0]        s_rd_ff, c_rd_ff;
   logic signed [SUM_W-1:0] u_rd_ff;
   logic [SA_W-1:0]         s_ra, s_wa;
   logic [CA_W-1:0]         c_ra, c_wa, u_ra;
   logic                    smem_we, cmem_we;
   logic [VAL_W-1:0]        c_wd;
   logic signed [SUM_W-1:0] u_wd;

   // Control registers.
   logic [3:0]        state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic [ERR_W-1:0]  prev_ff, prev_in;
   logic [VCNT_W-1:0] n_ff, n_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [VIDX_W-1:0] v_ff, v_in;
   logic [SA_W-1:0]   vbase_ff, vbase_in;
   logic [CL_W-1:0]   c_ff, c_in;
   logic [CA_W-1:0]   cbase_ff, cbase_in;
   logic [DIM_W-1:0]  j_ff, j_in;
   logic [CL_W-1:0]   best_ff, best_in;
   logic [DIST_W-1:0] bestd_ff, bestd_in;
   logic [CA_W-1:0]   bbase_ff, bbase_in;
   logic              first_ff, first_in;
   logic [CNT_W-1:0]  chold_ff, chold_in;
   logic [CNT_W-1:0]  counts_ff [NUM_CLUSTERS];
   logic [CNT_W-1:0]  counts_in [NUM_CLUSTERS];
   logic              pend_ff, pend_in;
   logic              rdok_ff, rdok_in;
   logic [VCFG_W-1:0] vcount_ff, vcount_in;
   logic [CAP_W-1:0]  icap_ff, icap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [PASS_W-1:0] rsp_pass_ff, rsp_pass_in;

   // Distance pipeline and accumulate write stage.
   logic              s1_vld_ff, s1_vld_in, s1_first_ff, s1_first_in, s1_last_ff, s1_last_in;
   logic [CL_W-1:0]   s1_c_ff, s1_c_in;
   logic [CA_W-1:0]   s1_cb_ff, s1_cb_in;
   logic              s2_vld_ff, s2_first_ff, s2_last_ff;
   logic [CL_W-1:0]   s2_c_ff;
   logic [CA_W-1:0]   s2_cb_ff;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic              a1_vld_ff, a1_vld_in;
   logic [CA_W-1:0]   a1_addr_ff, a1_addr_in;

   logic signed [VAL_W:0]     diff;
   logic signed [2*VAL_W+1:0] prod;
   logic [DIST_W-1:0]         dist_cur;
   logic                      take;
   logic [CL_W-1:0]           fin_best;
   logic [DIST_W-1:0]         fin_dist;
   logic [CA_W-1:0]           fin_base;
   logic [ERR_W:0]            err_sum;
   logic [ERR_W-1:0]          err_sat;
   logic [CL_W-1:0]           cnt_idx;
   logic [CNT_W-1:0]          cnt_sel;
   logic                      any_empty;
   logic                      req_fire;
   logic                      samp_ok, cent_ok;
   logic [SA_W-1:0]           samp_addr;
   logic [CA_W-1:0]           cent_addr;
   logic                      j_last, c_last;
   logic                      finish;
   logic [1:0]                fin_status;
   logic [ERR_W-1:0]          fin_err;
   logic                      div_start;
   logic [VAL_W-1:0]          div_q;
   kct_div_stat_type          div_stat;

   kct_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (u_rd_ff),
      .divisor  (cnt_sel),
      .quotient (div_q),
      .stat     (div_stat)
   );

   // Request decode.
   assign req_ready = (state_ff == S_IDLE) && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign samp_ok   = (17'(req_vector_index) < 17'(MAX_VECTORS))
                      && (6'(req_component) < 6'(DIMENSIONS));
   assign cent_ok   = (req_vector_index < 10'(NUM_CLUSTERS))
                      && (6'(req_component) < 6'(DIMENSIONS));
   assign samp_addr = SA_W'(req_vector_index) * SA_W'(DIMENSIONS) + SA_W'(req_component);
   assign cent_addr = CA_W'(req_vector_index) * CA_W'(DIMENSIONS) + CA_W'(req_component);

   // Memory addresses by phase.
   assign s_ra = vbase_ff + SA_W'(j_ff);
   assign s_wa = samp_addr;
   assign c_ra = (state_ff == S_IDLE) ? cent_addr : (cbase_ff + CA_W'(j_ff));
   assign u_ra = (state_ff == S_ACC) ? (bbase_ff + CA_W'(j_ff)) : (cbase_ff + CA_W'(j_ff));
   assign u_wd = (first_ff ? SUM_W'(0) : u_rd_ff)
                 + {{(SUM_W-VAL_W){s_rd_ff[VAL_W-1]}}, s_rd_ff};

   // Squared difference of one component pair.
   assign diff  = {s_rd_ff[VAL_W-1], s_rd_ff} - {c_rd_ff[VAL_W-1], c_rd_ff};
   assign prod  = diff * diff;
   assign sq_in = prod[SQ_W-1:0];

   // Distance accumulation and nearest-centroid choice; ties keep the lower index.
   assign dist_cur = s2_first_ff ? DIST_W'(sq_ff) : (acc_ff + DIST_W'(sq_ff));
   assign take     = (s2_c_ff == '0) || (dist_cur < bestd_ff);
   assign fin_best = take ? s2_c_ff : best_ff;
   assign fin_dist = take ? dist_cur : bestd_ff;
   assign fin_base = take ? s2_cb_ff : bbase_ff;
   assign err_sum  = {1'b0, err_ff} + (ERR_W+1)'(fin_dist);
   assign err_sat  = err_sum[ERR_W] ? {ERR_W{1'b1}} : err_sum[ERR_W-1:0];

   // Cluster count lookup and empty check.
   assign cnt_idx = (state_ff == S_DDRAIN) ? fin_best : c_ff;
   assign cnt_sel = counts_ff[cnt_idx];
   always_comb begin
      any_empty = 1'b0;
      for (int k = 0; k < NUM_CLUSTERS; k++) begin
         if (counts_ff[k] == '0) any_empty = 1'b1;
      end
   end

   assign j_last = (j_ff == DIM_W'(DIMENSIONS - 1));
   assign c_last = (c_ff == CL_W'(NUM_CLUSTERS - 1));

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      err_in        = err_ff;
      prev_in       = prev_ff;
      n_in          = n_ff;
      cap_in        = cap_ff;
      v_in          = v_ff;
      vbase_in      = vbase_ff;
      c_in          = c_ff;
      cbase_in      = cbase_ff;
      j_in          = j_ff;
      best_in       = best_ff;
      bestd_in      = bestd_ff;
      bbase_in      = bbase_ff;
      first_in      = first_ff;
      chold_in      = chold_ff;
      counts_in     = counts_ff;
      pend_in       = pend_ff;
      rdok_in       = rdok_ff;
      vcount_in     = vcount_ff;
      icap_in       = icap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pass_in   = rsp_pass_ff;
      s1_vld_in     = 1'b0;
      s1_first_in   = (j_ff == '0);
      s1_last_in    = j_last;
      s1_c_in       = c_ff;
      s1_cb_in      = cbase_ff;
      acc_in        = acc_ff;
      a1_vld_in     = 1'b0;
      a1_addr_in    = u_ra;
      smem_we       = 1'b0;
      cmem_we       = 1'b0;
      c_wa          = cent_addr;
      c_wd          = req_sample_value;
      div_start     = 1'b0;
      finish        = 1'b0;
      fin_status    = STATUS_CONVERGED;
      fin_err       = err_ff;

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_VECTOR_COUNT:  vcount_in = csr_wdata;
            CSR_ITERATION_CAP: icap_in   = csr_wdata[CAP_W-1:0];
            default:           vcount_in = vcount_ff;
         endcase
      end

      // Last stage of the distance pipeline.
      if (s2_vld_ff) begin
         acc_in = dist_cur;
         if (s2_last_ff) begin
            best_in  = fin_best;
            bestd_in = fin_dist;
            bbase_in = fin_base;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rdok_ff ? c_rd_ff : '0;
               rsp_err_in    = prev_ff;
               rsp_status_in = STATUS_READBACK;
               rsp_pass_in   = pass_ff;
               pend_in       = 1'b0;
            end
            if (req_fire) begin
               unique case (req_mode)
                  MODE_LOAD_SAMPLE:   smem_we = samp_ok;
                  MODE_LOAD_CENTROID: cmem_we = cent_ok;
                  MODE_START: begin
                     prev_in  = '0;
                     pass_in  = '0;
                     n_in     = (CMP_W'(vcount_ff) > CMP_W'(MAX_VECTORS))
                                ? VCNT_W'(MAX_VECTORS) : VCNT_W'(vcount_ff);
                     cap_in   = (icap_ff == '0) ? CAP_W'(1) : icap_ff;
                     state_in = S_PASS;
                  end
                  MODE_READ: begin
                     pend_in = 1'b1;
                     rdok_in = cent_ok;
                  end
                  default: pend_in = pend_ff;
               endcase
            end
         end
         S_PASS: begin
            pass_in  = pass_ff + 1'b1;
            err_in   = '0;
            v_in     = '0;
            vbase_in = '0;
            c_in     = '0;
            cbase_in = '0;
            j_in     = '0;
            for (int k = 0; k < NUM_CLUSTERS; k++) counts_in[k] = '0;
            state_in = (n_ff == '0) ? S_CHECK : S_DIST;
         end
         S_DIST: begin
            // Issue one sample and one centroid component read per cycle.
            s1_vld_in = 1'b1;
            if (j_last) begin
               j_in = '0;
               if (c_last) begin
                  c_in     = '0;
                  cbase_in = '0;
                  state_in = S_DDRAIN;
               end else begin
                  c_in     = c_ff + 1'b1;
                  cbase_in = cbase_ff + CA_W'(DIMENSIONS);
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_DDRAIN: begin
            if (s2_vld_ff && s2_last_ff && (s2_c_ff == CL_W'(NUM_CLUSTERS - 1))) begin
               err_in   = err_sat;
               first_in = (cnt_sel == '0);
               chold_in = cnt_sel;
               j_in     = '0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            // Read sum and sample; the add and write land in the next cycle.
            a1_vld_in = 1'b1;
            if (j_last) begin
               j_in = '0;
               for (int k = 0; k < NUM_CLUSTERS; k++) begin
                  if (best_ff == CL_W'(k)) counts_in[k] = chold_ff + 1'b1;
               end
               v_in     = v_ff + 1'b1;
               vbase_in = vbase_ff + SA_W'(DIMENSIONS);
               state_in = ((VCNT_W'(v_ff) + 1'b1) == n_ff) ? S_CHECK : S_DIST;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (any_empty) begin
               finish     = 1'b1;
               fin_status = STATUS_EMPTY;
               fin_err    = prev_ff;
            end else begin
               c_in     = '0;
               cbase_in = '0;
               j_in     = '0;
               state_in = S_DRD;
            end
         end
         S_DRD: begin
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWT;
         end
         S_DWT: begin
            if (div_stat.done) begin
               cmem_we = 1'b1;
               c_wa    = cbase_ff + CA_W'(j_ff);
               c_wd    = div_q;
               if (j_last) begin
                  j_in = '0;
                  if (c_last) begin
                     state_in = S_END;
                  end else begin
                     c_in     = c_ff + 1'b1;
                     cbase_in = cbase_ff + CA_W'(DIMENSIONS);
                     state_in = S_DRD;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_DRD;
               end
            end
         end
         S_END: begin
            prev_in = err_ff;
            if (err_ff == prev_ff) begin
               finish     = 1'b1;
               fin_status = STATUS_CONVERGED;
            end else if (pass_ff >= cap_ff) begin
               finish     = 1'b1;
               fin_status = STATUS_CAP;
            end else begin
               state_in = S_PASS;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Run result word.
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_err_in    = fin_err;
         rsp_status_in = fin_status;
         rsp_pass_in   = pass_ff;
         state_in      = S_IDLE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= '0;
         prev_ff      <= '0;
         pend_ff      <= 1'b0;
         vcount_ff    <= VCOUNT_RESET;
         icap_ff      <= ICAP_RESET;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         a1_vld_ff    <= 1'b0;
         for (int k = 0; k < NUM_CLUSTERS; k++) counts_ff[k] <= '0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         prev_ff      <= prev_in;
         pend_ff      <= pend_in;
         vcount_ff    <= vcount_in;
         icap_ff      <= icap_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s1_vld_ff;
         a1_vld_ff    <= a1_vld_in;
         counts_ff    <= counts_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      err_ff        <= err_in;
      n_ff          <= n_in;
      cap_ff        <= cap_in;
      v_ff          <= v_in;
      vbase_ff      <= vbase_in;
      c_ff          <= c_in;
      cbase_ff      <= cbase_in;
      j_ff          <= j_in;
      best_ff       <= best_in;
      bestd_ff      <= bestd_in;
      bbase_ff      <= bbase_in;
      first_ff      <= first_in;
      chold_ff      <= chold_in;
      rdok_ff       <= rdok_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pass_ff   <= rsp_pass_in;
      s1_first_ff   <= s1_first_in;
      s1_last_ff    <= s1_last_in;
      s1_c_ff       <= s1_c_in;
      s1_cb_ff      <= s1_cb_in;
      s2_first_ff   <= s1_first_ff;
      s2_last_ff    <= s1_last_ff;
      s2_c_ff       <= s1_c_ff;
      s2_cb_ff      <= s1_cb_ff;
      sq_ff         <= sq_in;
      acc_ff        <= acc_in;
      a1_addr_ff    <= a1_addr_in;
   end

   // Sample memory: load writes, one read per cycle.
   always_ff @(posedge clock) begin
      if (smem_we) smem[s_wa] <= req_sample_value;
      s_rd_ff <= smem[s_ra];
   end

   // Centroid memory: load and update writes, distance and readback reads.
   always_ff @(posedge clock) begin
      if (cmem_we) cmem[c_wa] <= c_wd;
      c_rd_ff <= cmem[c_ra];
   end

   // Cluster sum memory: read-modify-write during accumulation, reads for the centroid division.
   always_ff @(posedge clock) begin
      if (a1_vld_ff) umem[a1_addr_ff] <= u_wd;
      u_rd_ff <= umem[u_ra];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_centroid_value = rsp_value_ff;
   assign rsp_total_error    = rsp_err_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_passes_done    = rsp_pass_ff;

`ifndef NO_ASSERTIONS
   // A sum write never lands while the update phase reads sums.
   a_acc_vs_div : assert property (@(posedge clock) disable iff (reset)
      a1_vld_ff |-> (state_ff != S_DRD) && (state_ff != S_DSTART) && (state_ff != S_DWT))
      else $error("sum write overlaps centroid update");

   // The divider only reports while the sequencer waits for it.
   a_div_done : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DWT))
      else $error("divider done outside its wait state");

   // A pending readback always finds the response register empty.
   a_pend_free : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("readback would overwrite a waiting word");

   // The distance pipeline drains before accumulation starts.
   a_pipe_drain : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> !s1_vld_ff && !s2_vld_ff)
      else $error("distance pipeline busy during accumulation");
`endif

endmodule
